/* design/ipv4_transport_header_parser_macros.svh */
// Assertion macros for the IPv4 transport header parser.
// Used by the top level only; no other dependencies.
`ifndef IPV4_TRANSPORT_HEADER_PARSER_MACROS_SVH
`define IPV4_TRANSPORT_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ITHP_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ITHP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/ithp_pkg.sv */
// Shared types and constants of the IPv4 transport header parser.
// No dependencies.
package ithp_pkg;

   localparam logic [15:0] MIN_HDR_LEN    = 16'd20;
   localparam logic [15:0] TCP_MIN_LEN    = 16'd20;
   localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
   localparam logic [15:0] BYTE_COUNT_MAX = 16'hFFFF;
   localparam logic [3:0]  VERSION_IPV4   = 4'd4;

   localparam logic [7:0]  PROTO_ICMP = 8'd1;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;

   // byte offsets in the IPv4 header
   localparam logic [15:0] POS_VER_IHL   = 16'd0;
   localparam logic [15:0] POS_TLEN_HI   = 16'd2;
   localparam logic [15:0] POS_TLEN_LO   = 16'd3;
   localparam logic [15:0] POS_PROTO     = 16'd9;
   localparam logic [15:0] POS_SRC_FIRST = 16'd12;
   localparam logic [15:0] POS_SRC_LAST  = 16'd15;
   localparam logic [15:0] POS_DST_FIRST = 16'd16;
   localparam logic [15:0] POS_DST_LAST  = 16'd19;

   // byte offsets in the transport header
   localparam logic [15:0] TP_SPORT_HI = 16'd0;
   localparam logic [15:0] TP_SPORT_LO = 16'd1;
   localparam logic [15:0] TP_DPORT_HI = 16'd2;
   localparam logic [15:0] TP_DPORT_LO = 16'd3;
   localparam logic [15:0] TP_DOFF     = 16'd12;
   localparam logic [15:0] TP_FLAGS    = 16'd13;

   typedef struct packed {
      logic [15:0] byte_count;
      logic [5:0]  hdr_len;
      logic        version_ok;
      logic [15:0] tot_len;
      logic [7:0]  proto;
      logic [31:0] saddr;
      logic [31:0] daddr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  flags;
      logic [5:0]  tcp_offset;
   } ithp_state_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] saddr;
      logic [31:0] daddr;
      logic [7:0]  proto;
      logic [15:0] ip_tot_len;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  flags_byte;
      logic [15:0] data_len;
   } ithp_result_type;

endpackage

/* design/ithp_capture.sv */
// Byte capture stage: tracks the byte position and grabs header fields.
// On the last byte of a packet it hands a snapshot on. Uses ithp_pkg.
module ithp_capture (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_pkt_byte,
   input  logic                    req_last_byte,
   output logic                    snap_valid,
   input  logic                    snap_ready,
   output ithp_pkg::ithp_state_type snap
);
   import ithp_pkg::*;

   ithp_state_type st_ff, st_in, next_st;
   ithp_state_type snap_ff, snap_in;
   logic           snap_valid_ff, snap_valid_in;
   logic           accept, take;
   logic [15:0]    pos, tp;

   assign take      = snap_valid_ff & snap_ready;
   assign req_ready = ~snap_valid_ff | take;
   assign accept    = req_valid & req_ready;
   assign pos       = st_ff.byte_count;

   // field capture for the byte at the current position
   always_comb begin
      next_st = st_ff;
      tp      = '0;
      if (pos == POS_VER_IHL) begin
         next_st.version_ok = (req_pkt_byte[7:4] == VERSION_IPV4);
         next_st.hdr_len    = {req_pkt_byte[3:0], 2'b00};
      end else if (pos == POS_TLEN_HI) begin
         next_st.tot_len[15:8] = req_pkt_byte;
      end else if (pos == POS_TLEN_LO) begin
         next_st.tot_len[7:0] = req_pkt_byte;
      end else if (pos == POS_PROTO) begin
         next_st.proto = req_pkt_byte;
      end else if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
         next_st.saddr = {st_ff.saddr[23:0], req_pkt_byte};
      end else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) begin
         next_st.daddr = {st_ff.daddr[23:0], req_pkt_byte};
      end
      // transport bytes, relative to the (possibly just updated) header length
      if ({10'd0, next_st.hdr_len} >= MIN_HDR_LEN && pos >= {10'd0, next_st.hdr_len}) begin
         tp = pos - {10'd0, next_st.hdr_len};
         if (tp == TP_SPORT_HI) begin
            next_st.sport[15:8] = req_pkt_byte;
         end else if (tp == TP_SPORT_LO) begin
            next_st.sport[7:0] = req_pkt_byte;
         end else if (tp == TP_DPORT_HI) begin
            next_st.dport[15:8] = req_pkt_byte;
         end else if (tp == TP_DPORT_LO) begin
            next_st.dport[7:0] = req_pkt_byte;
         end else if (tp == TP_DOFF) begin
            next_st.tcp_offset = {req_pkt_byte[7:4], 2'b00};
         end else if (tp == TP_FLAGS) begin
            next_st.flags = req_pkt_byte;
         end
      end
      if (pos != BYTE_COUNT_MAX) begin
         next_st.byte_count = pos + 16'd1;
      end
   end

   always_comb begin
      st_in         = st_ff;
      snap_in       = snap_ff;
      snap_valid_in = snap_valid_ff & ~take;
      if (accept) begin
         if (req_last_byte) begin
            snap_in       = next_st;
            snap_valid_in = 1'b1;
            st_in         = '0;
         end else begin
            st_in = next_st;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         st_ff         <= st_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

/* design/ithp_check.sv */
// Check stage: validates a packet snapshot and registers the result item.
// Uses ithp_pkg.
module ithp_check (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     snap_valid,
   output logic                     snap_ready,
   input  ithp_pkg::ithp_state_type snap,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ithp_pkg::ithp_result_type rsp
);
   import ithp_pkg::*;

   ithp_result_type rsp_ff, rsp_in, res;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            load;
   logic [15:0]     hdr, tl, off;
   logic            pass;

   assign snap_ready = ~rsp_valid_ff | rsp_ready;
   assign load       = snap_valid & snap_ready;
   assign hdr        = {10'd0, snap.hdr_len};
   assign off        = {10'd0, snap.tcp_offset};
   assign tl         = snap.tot_len - hdr;

   always_comb begin
      pass = (snap.byte_count >= MIN_HDR_LEN) && snap.version_ok &&
             (hdr >= MIN_HDR_LEN) && (hdr <= snap.byte_count) &&
             (snap.tot_len <= snap.byte_count) && (snap.tot_len >= hdr);
      res = '0;
      if (pass) begin
         res.ok         = 1'b1;
         res.saddr      = snap.saddr;
         res.daddr      = snap.daddr;
         res.proto      = snap.proto;
         res.ip_tot_len = snap.tot_len;
         if (snap.proto == PROTO_TCP && tl >= TCP_MIN_LEN) begin
            res.sport      = snap.sport;
            res.dport      = snap.dport;
            res.flags_byte = snap.flags;
            if (off <= tl) begin
               res.data_len = tl - off;
            end
         end else if (snap.proto == PROTO_UDP && tl >= UDP_HDR_LEN) begin
            res.sport    = snap.sport;
            res.dport    = snap.dport;
            res.data_len = tl - UDP_HDR_LEN;
         end else if (snap.proto == PROTO_ICMP) begin
            res.data_len = tl;
         end
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (load) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* design/ipv4_transport_header_parser.sv */
// IPv4 transport header parser, top level.
// Input channel (req_): one raw packet byte per item, in wire order, with
// req_last_byte marking the final byte of the packet buffer.
// Result channel (rsp_): one item per packet, sent for the marked byte: a
// pass flag, addresses, protocol, total length, TCP/UDP ports, TCP flags and
// transport payload length. A failed packet gives rsp_ok low, all else zero.
// Throughput: one byte per cycle, sustained, across packet boundaries, while
// rsp_ready stays high. Path: once the last byte is taken, the capture stage,
// whose field registers feed a snapshot register, hands on to the check stage,
// which compares and subtracts into the result register that drives rsp_.
// If rsp_ready stays low the result register holds, the snapshot register
// fills behind it, and req_ready then drops until the result is taken; until
// then non-final bytes are held off as well.
// Reset (synchronous, active high) clears the byte count, captured fields and
// both valid flags; any partly received packet is dropped.
// Depends on ithp_pkg, ithp_capture, ithp_check and the assertion macros.
`include "ipv4_transport_header_parser_macros.svh"

module ipv4_transport_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pkt_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [31:0] rsp_saddr,
   output logic [31:0] rsp_daddr,
   output logic [7:0]  rsp_proto,
   output logic [15:0] rsp_ip_tot_len,
   output logic [15:0] rsp_sport,
   output logic [15:0] rsp_dport,
   output logic [7:0]  rsp_flags_byte,
   output logic [15:0] rsp_data_len
);
   import ithp_pkg::*;

   ithp_state_type  snap;
   ithp_result_type rsp;
   logic            snap_valid, snap_ready;

   ithp_capture u_capture (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pkt_byte  (req_pkt_byte),
      .req_last_byte (req_last_byte),
      .snap_valid    (snap_valid),
      .snap_ready    (snap_ready),
      .snap          (snap)
   );

   ithp_check u_check (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_ok         = rsp.ok;
   assign rsp_saddr      = rsp.saddr;
   assign rsp_daddr      = rsp.daddr;
   assign rsp_proto      = rsp.proto;
   assign rsp_ip_tot_len = rsp.ip_tot_len;
   assign rsp_sport      = rsp.sport;
   assign rsp_dport      = rsp.dport;
   assign rsp_flags_byte = rsp.flags_byte;
   assign rsp_data_len   = rsp.data_len;

   `ITHP_ASSERT_NEXT(a_last_fills_snap, req_valid && req_ready && req_last_byte, snap_valid, "last byte taken but no snapshot")
   `ITHP_ASSERT_IMPL(a_rsp_from_snap, $rose(rsp_valid), $past(snap_valid), "result without a snapshot")
   `ITHP_ASSERT_IMPL(a_fail_zeroes, rsp_valid && !rsp_ok, rsp_saddr == 32'd0 && rsp_dport == 16'd0 && rsp_data_len == 16'd0, "failed packet with non-zero fields")

endmodule
